// ===== design/link_connection_manager_core_defines.svh =====
// Assertion macros of the link connection manager design, used by the sequencer.
`ifndef LINK_CONNECTION_MANAGER_CORE_DEFINES_SVH
`define LINK_CONNECTION_MANAGER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that the consequent holds in the same cycle as the antecedent.
`define LCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcm check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcm check failed");

`else

`define LCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/lcm_pkg.sv =====
// Shared types, widths and codes of the link connection manager.
package lcm_pkg;

    localparam int unsigned NOW_W   = 32;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned DLY_W   = 16;
    localparam int unsigned CAP_W   = 20;
    localparam int unsigned PROD_W  = DLY_W + CNT_W;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = CAP_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_CAP = 3'd4;

    // Configuration reset values
    localparam logic [CNT_W-1:0] DROP_LIMIT_RST  = 8'd3;
    localparam logic [DLY_W-1:0] START_DELAY_RST = 16'd1000;
    localparam logic [DLY_W-1:0] RETRY_DELAY_RST = 16'd5000;
    localparam logic [DLY_W-1:0] BACKOFF_STEP_RST = 16'd5000;
    localparam logic [CAP_W-1:0] BACKOFF_CAP_RST = 20'd60000;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] drop_confirm_limit;
        logic [DLY_W-1:0] start_delay_ms;
        logic [DLY_W-1:0] retry_delay_ms;
        logic [DLY_W-1:0] backoff_step_ms;
        logic [CAP_W-1:0] backoff_cap_ms;
    } t_lcm_cfg;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             modem_ready;
        logic             link_up;
        logic             init_ok;
        logic             start_ok;
        logic             link_up_after_start;
    } t_lcm_item;

    typedef struct packed {
        logic [STATE_W-1:0] conn_state;
        logic [ACT_W-1:0]   action_issued;
        logic [CNT_W-1:0]   attempt_count;
        logic               has_connectivity;
    } t_lcm_result;

endpackage

// ===== design/lcm_in_if.sv =====
// Input channel of the link connection manager: one tick per transfer.
interface lcm_in_if;
    import lcm_pkg::*;

    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;
    logic             modem_ready;
    logic             link_up;
    logic             init_ok;
    logic             start_ok;
    logic             link_up_after_start;

    modport source (
        output valid, now_ms, modem_ready, link_up, init_ok, start_ok,
               link_up_after_start,
        input  ready
    );

    modport sink (
        input  valid, now_ms, modem_ready, link_up, init_ok, start_ok,
               link_up_after_start,
        output ready
    );
endinterface

// ===== design/lcm_out_if.sv =====
// Result channel of the link connection manager: one result per transfer.
interface lcm_out_if;
    import lcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] conn_state;
    logic [ACT_W-1:0]   action_issued;
    logic [CNT_W-1:0]   attempt_count;
    logic               has_connectivity;

    modport source (
        output valid, conn_state, action_issued, attempt_count, has_connectivity,
        input  ready
    );

    modport sink (
        input  valid, conn_state, action_issued, attempt_count, has_connectivity,
        output ready
    );
endinterface

// ===== design/lcm_seq.sv =====
// Connection sequencer: state, counters and deadline, one tick per advance.
`include "link_connection_manager_core_defines.svh"

module lcm_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  lcm_pkg::t_lcm_item   i_item,
    input  lcm_pkg::t_lcm_cfg    i_cfg,
    output lcm_pkg::t_lcm_result o_res
);
    import lcm_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        ST_WAIT    = 3'd0,
        ST_INIT    = 3'd1,
        ST_START   = 3'd2,
        ST_ONLINE  = 3'd3,
        ST_BACKOFF = 3'd4
    } t_conn_state;

    t_conn_state      r_state, n_state;
    logic [CNT_W-1:0] r_attempts, n_attempts;
    logic [CNT_W-1:0] r_missing, n_missing;
    logic [NOW_W-1:0] r_next_time, n_next_time;

    logic [NOW_W-1:0]  w_diff;
    logic              w_due;
    logic [CNT_W-1:0]  w_mult;
    logic [PROD_W-1:0] w_prod;
    logic [CAP_W-1:0]  w_delay;
    logic [CNT_W-1:0]  w_missing_inc;
    logic [ACT_W-1:0]  w_action;
    logic              w_link;

    // Wrap-safe deadline test: a zero deadline never blocks
    assign w_diff = i_item.now_ms - r_next_time;
    assign w_due  = (r_next_time == '0) || !w_diff[NOW_W-1];

    // Backoff delay: min(cap, step * max(1, attempts))
    assign w_mult  = (r_attempts == '0) ? CNT_W'(1) : r_attempts;
    assign w_prod  = {{CNT_W{1'b0}}, i_cfg.backoff_step_ms} * {{DLY_W{1'b0}}, w_mult};
    assign w_delay = (w_prod > {{(PROD_W-CAP_W){1'b0}}, i_cfg.backoff_cap_ms})
                   ? i_cfg.backoff_cap_ms : w_prod[CAP_W-1:0];

    assign w_missing_inc = r_missing + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_attempts  = r_attempts;
        n_missing   = r_missing;
        n_next_time = r_next_time;
        w_action    = ACT_NONE;

        if (!i_item.modem_ready) begin
            if (r_state != ST_WAIT) begin
                n_state     = ST_WAIT;
                n_attempts  = '0;
                n_missing   = '0;
                n_next_time = '0;
            end
        end else if (r_state == ST_START && i_item.link_up) begin
            n_state     = ST_ONLINE;
            n_attempts  = '0;
            n_missing   = '0;
            n_next_time = '0;
        end else if (r_state == ST_ONLINE) begin
            if (!i_item.link_up) begin
                n_missing = w_missing_inc;
                if (w_missing_inc >= i_cfg.drop_confirm_limit) begin
                    n_missing   = '0;
                    n_attempts  = r_attempts + CNT_W'(1);
                    n_state     = ST_BACKOFF;
                    n_next_time = i_item.now_ms
                                + {{(NOW_W-DLY_W){1'b0}}, i_cfg.retry_delay_ms};
                end
            end else begin
                n_missing   = '0;
                n_next_time = '0;
            end
        end else if (w_due) begin
            case (r_state)
                ST_INIT: begin
                    w_action = ACT_INIT;
                    if (i_item.init_ok) begin
                        n_state     = ST_START;
                        n_next_time = i_item.now_ms
                                    + {{(NOW_W-DLY_W){1'b0}}, i_cfg.start_delay_ms};
                    end else begin
                        n_attempts  = r_attempts + CNT_W'(1);
                        n_state     = ST_BACKOFF;
                        n_next_time = i_item.now_ms
                                    + {{(NOW_W-DLY_W){1'b0}}, i_cfg.retry_delay_ms};
                    end
                end
                ST_START: begin
                    w_action = ACT_START;
                    if (i_item.start_ok && i_item.link_up_after_start) begin
                        n_state     = ST_ONLINE;
                        n_attempts  = '0;
                        n_missing   = '0;
                        n_next_time = '0;
                    end else begin
                        n_attempts  = r_attempts + CNT_W'(1);
                        n_state     = ST_BACKOFF;
                        n_next_time = i_item.now_ms
                                    + {{(NOW_W-DLY_W){1'b0}}, i_cfg.retry_delay_ms};
                    end
                end
                ST_BACKOFF: begin
                    n_state     = ST_START;
                    n_next_time = i_item.now_ms + {{(NOW_W-CAP_W){1'b0}}, w_delay};
                end
                default: begin
                    n_attempts  = '0;
                    n_missing   = '0;
                    n_state     = ST_INIT;
                    n_next_time = i_item.now_ms;
                end
            endcase
        end
    end

    assign w_link = (w_action == ACT_START) ? i_item.link_up_after_start
                                            : i_item.link_up;

    always_comb begin
        o_res.conn_state       = n_state;
        o_res.action_issued    = w_action;
        o_res.attempt_count    = n_attempts;
        o_res.has_connectivity = (n_state == ST_ONLINE) && i_item.modem_ready && w_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_attempts  <= '0;
            r_missing   <= '0;
            r_next_time <= '0;
        end else if (i_adv) begin
            r_state     <= n_state;
            r_attempts  <= n_attempts;
            r_missing   <= n_missing;
            r_next_time <= n_next_time;
        end
    end

    `LCM_ASSERT_NOW(a_online_no_attempts, i_clk, i_rst_n,
        r_state == ST_ONLINE, r_attempts == '0)
    `LCM_ASSERT_NOW(a_online_no_deadline, i_clk, i_rst_n,
        r_state == ST_ONLINE, r_next_time == '0)
    `LCM_ASSERT_NOW(a_missing_only_online, i_clk, i_rst_n,
        r_state != ST_ONLINE, r_missing == '0)
    `LCM_ASSERT_NEXT(a_init_leaves_init, i_clk, i_rst_n,
        i_adv && w_action == ACT_INIT, r_state == ST_START || r_state == ST_BACKOFF)

endmodule

// ===== design/link_connection_manager_core.sv =====
// Path: a tick waits in the input register and advances into the result register together
//   with the sequencer state once the result register is empty or being drained.
// Throughput: one tick per cycle while the result channel drains without stalling.
// Reset: synchronous, active low; clears the sequencer to wait-ready with zero counters and
//   no deadline, empties both pipeline registers and loads the configuration defaults.
// Ticks and results move over valid/ready channels; a full input register still takes a
//   new transfer in the cycle it hands its tick on.
module link_connection_manager_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lcm_in_if.sink                        i_in,
    lcm_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [lcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lcm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import lcm_pkg::*;

    t_lcm_cfg    r_cfg;
    logic        r_in_valid;
    t_lcm_item   r_item;
    logic        r_out_valid;
    t_lcm_result r_res;

    t_lcm_result w_res;
    logic        w_adv;
    logic        w_in_take;

    // Advance the held tick when the result register is empty or being drained
    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    // Configuration: a write to an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_confirm_limit <= DROP_LIMIT_RST;
            r_cfg.start_delay_ms     <= START_DELAY_RST;
            r_cfg.retry_delay_ms     <= RETRY_DELAY_RST;
            r_cfg.backoff_step_ms    <= BACKOFF_STEP_RST;
            r_cfg.backoff_cap_ms     <= BACKOFF_CAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DROP_LIMIT:   r_cfg.drop_confirm_limit <= i_cfg_wdata[CNT_W-1:0];
                CFG_START_DELAY:  r_cfg.start_delay_ms     <= i_cfg_wdata[DLY_W-1:0];
                CFG_RETRY_DELAY:  r_cfg.retry_delay_ms     <= i_cfg_wdata[DLY_W-1:0];
                CFG_BACKOFF_STEP: r_cfg.backoff_step_ms    <= i_cfg_wdata[DLY_W-1:0];
                CFG_BACKOFF_CAP:  r_cfg.backoff_cap_ms     <= i_cfg_wdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the tick until the sequencer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.now_ms              <= i_in.now_ms;
            r_item.modem_ready         <= i_in.modem_ready;
            r_item.link_up             <= i_in.link_up;
            r_item.init_ok             <= i_in.init_ok;
            r_item.start_ok            <= i_in.start_ok;
            r_item.link_up_after_start <= i_in.link_up_after_start;
        end
    end

    lcm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Result register: load on advance, drop on a transfer with nothing behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.conn_state       = r_res.conn_state;
    assign o_out.action_issued    = r_res.action_issued;
    assign o_out.attempt_count    = r_res.attempt_count;
    assign o_out.has_connectivity = r_res.has_connectivity;

endmodule
